FILE: design/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder.
`default_nettype none
package arpc_pkg;

  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_PACKET = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_BAD_HW = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  localparam logic [15:0] ARP_MIN_LEN = 16'd28;
  localparam logic [15:0] HW_TYPE_ETH = 16'd1;
  localparam logic [7:0] HW_LEN_ETH = 8'd6;
  localparam logic [7:0] PADDR_LEN_IP = 8'd4;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        req_type;
    logic [31:0] lookup_ip;
    logic [15:0] pkt_len;
    logic [15:0] hw_type;
    logic [7:0]  hw_len;
    logic [7:0]  paddr_len;
    logic [15:0] opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [47:0] found_mac;
    logic [1:0]  send_kind;
    logic [47:0] send_dst_mac;
    logic [31:0] send_target_ip;
  } result_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/arpc_ram.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module arpc_ram (
  input  wire                              clk,
  input  wire                              wr_en,
  input  wire  [arpc_pkg::IDX_W-1:0]       wr_addr,
  input  arpc_pkg::entry_t                 wr_data,
  input  wire  [arpc_pkg::IDX_W-1:0]       rd_addr,
  output arpc_pkg::entry_t                 rd_data
);

  arpc_pkg::entry_t mem [arpc_pkg::CACHE_ENTRIES];
  arpc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: design/arp_cache_and_responder.sv
// Top level: ARP cache lookup, learning with oldest-first eviction, reply flagging.
//
// One transaction at a time: start is taken while busy is low, and exactly one
// result follows as a single-cycle out_valid strobe that cannot be held off.
// A packet that fails its checks answers in the cycle after it is taken. A
// lookup or a good packet walks the filled entries through the store's single
// read port, one entry per cycle behind its registered read data, stopping at
// the first match; a packet then passes through ST_WRITE for the write-back.
// With an empty cache a lookup answers straight from idle and a packet goes
// straight to ST_WRITE. Eviction costs nothing extra: the store is a ring
// whose oldest slot is overwritten. own_mac is accepted on the config port
// but no result field depends on it.
`default_nettype none
module arp_cache_and_responder (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  arpc_pkg::item_t                       in_item,
  output logic                                  out_valid,
  output arpc_pkg::result_t                     out_result,
  input  wire                                   cfg_we,
  input  wire  [arpc_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire  [arpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_t;

  localparam logic [arpc_pkg::IDX_W-1:0] IDX_LAST =
    arpc_pkg::IDX_W'(arpc_pkg::CACHE_ENTRIES - 1);
  localparam logic [arpc_pkg::CNT_W-1:0] CNT_FULL =
    arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES);

  state_t                       state_r;
  logic [arpc_pkg::CNT_W-1:0]   count_r;     // filled entries
  logic [arpc_pkg::IDX_W-1:0]   base_r;      // oldest slot once full
  logic [arpc_pkg::IDX_W-1:0]   addr_r;
  logic [arpc_pkg::IDX_W-1:0]   addr_prev_r;
  logic                         pend_r;      // read data matches addr_prev_r
  logic [arpc_pkg::IDX_W-1:0]   slot_r;
  logic                         new_r;
  logic                         is_pkt_r;
  logic                         reply_r;
  logic [31:0]                  key_r;
  logic [47:0]                  smac_r;
  logic [31:0]                  own_ip_r;
  logic                         out_valid_r;
  arpc_pkg::result_t            out_result_r;

  arpc_pkg::entry_t             rd_data;
  arpc_pkg::entry_t             wr_data;
  logic                         wr_en;
  logic [1:0]                   chk_status;
  logic                         accept;
  logic                         full;
  logic                         hit_now;
  logic                         last_now;
  logic [arpc_pkg::IDX_W-1:0]   free_slot;

  assign accept = start && (state_r == ST_IDLE);
  assign full = (count_r == CNT_FULL);
  assign free_slot = full ? base_r : count_r[arpc_pkg::IDX_W-1:0];
  assign hit_now = pend_r && (rd_data.ip == key_r);
  assign last_now = pend_r &&
    (arpc_pkg::CNT_W'(addr_prev_r) == (count_r - arpc_pkg::CNT_W'(1)));

  assign wr_en = (state_r == ST_WRITE);
  assign wr_data = '{ip: key_r, mac: smac_r};

  always_comb begin
    if (in_item.pkt_len < arpc_pkg::ARP_MIN_LEN) begin
      chk_status = arpc_pkg::STATUS_SHORT;
    end else if (in_item.hw_type != arpc_pkg::HW_TYPE_ETH) begin
      chk_status = arpc_pkg::STATUS_BAD_HW;
    end else if (in_item.hw_len != arpc_pkg::HW_LEN_ETH ||
                 in_item.paddr_len != arpc_pkg::PADDR_LEN_IP) begin
      chk_status = arpc_pkg::STATUS_BAD_LEN;
    end else begin
      chk_status = arpc_pkg::STATUS_OK;
    end
  end

  arpc_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_we && cfg_idx == arpc_pkg::CFG_OWN_IP) begin
      own_ip_r <= cfg_wdata[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            is_pkt_r <= in_item.req_type;
            key_r    <= (in_item.req_type == arpc_pkg::REQ_PACKET) ?
                        in_item.sender_ip : in_item.lookup_ip;
            smac_r   <= in_item.sender_mac;
            reply_r  <= (in_item.opcode == arpc_pkg::OP_REQUEST) &&
                        (in_item.target_ip == own_ip_r);
            addr_r   <= '0;
            pend_r   <= 1'b0;
            slot_r   <= '0;
            new_r    <= 1'b1;
            if (in_item.req_type == arpc_pkg::REQ_PACKET &&
                chk_status != arpc_pkg::STATUS_OK) begin
              out_valid_r         <= 1'b1;
              out_result_r        <= '0;
              out_result_r.status <= chk_status;
            end else if (count_r != '0) begin
              state_r <= ST_SCAN;
            end else if (in_item.req_type == arpc_pkg::REQ_PACKET) begin
              state_r <= ST_WRITE;
            end else begin
              out_valid_r                 <= 1'b1;
              out_result_r                <= '0;
              out_result_r.send_kind      <= arpc_pkg::KIND_REQUEST;
              out_result_r.send_dst_mac   <= arpc_pkg::MAC_BCAST;
              out_result_r.send_target_ip <= in_item.lookup_ip;
            end
          end
        end
        ST_SCAN: begin
          pend_r      <= 1'b1;
          addr_prev_r <= addr_r;
          if (addr_r != IDX_LAST) begin
            addr_r <= addr_r + 1'b1;
          end
          if (hit_now || last_now) begin
            if (is_pkt_r) begin
              slot_r  <= hit_now ? addr_prev_r : free_slot;
              new_r   <= !hit_now;
              state_r <= ST_WRITE;
            end else begin
              out_valid_r  <= 1'b1;
              out_result_r <= '0;
              state_r      <= ST_IDLE;
              if (hit_now) begin
                out_result_r.hit       <= 1'b1;
                out_result_r.found_mac <= rd_data.mac;
              end else begin
                out_result_r.send_kind      <= arpc_pkg::KIND_REQUEST;
                out_result_r.send_dst_mac   <= arpc_pkg::MAC_BCAST;
                out_result_r.send_target_ip <= key_r;
              end
            end
          end
        end
        ST_WRITE: begin
          if (new_r) begin
            if (full) begin
              base_r <= (base_r == IDX_LAST) ? '0 : base_r + 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
            end
          end
          out_valid_r  <= 1'b1;
          out_result_r <= '0;
          if (reply_r) begin
            out_result_r.send_kind      <= arpc_pkg::KIND_REPLY;
            out_result_r.send_dst_mac   <= smac_r;
            out_result_r.send_target_ip <= key_r;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire

FILE: design/arpc_checker.sv
// Port-level checks for the ARP cache and responder, bound to the top level.
`default_nettype none
module arpc_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               busy,
  input wire               out_valid,
  input arpc_pkg::result_t out_result
);

  // a lookup hit never asks for a transmit
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.hit |->
      out_result.send_kind == arpc_pkg::KIND_NONE &&
      out_result.status == arpc_pkg::STATUS_OK)
    else $error("hit result carries a send request");

  // dropped packets learn nothing and send nothing
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.status != arpc_pkg::STATUS_OK |->
      out_result.send_kind == arpc_pkg::KIND_NONE && !out_result.hit)
    else $error("dropped packet produced a send or hit");

  a_req_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.send_kind == arpc_pkg::KIND_REQUEST |->
      out_result.send_dst_mac == arpc_pkg::MAC_BCAST && !out_result.hit)
    else $error("broadcast request without broadcast MAC");

  // a long transaction ends with its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);
`default_nettype wire

FILE: dv/arp_cache_and_responder_tb.sv
// Self-checking testbench for the ARP cache and responder: directed and random stimulus.
`default_nettype none
module arp_cache_and_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] OP_REPLY = 16'd2;
  localparam logic [arpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [arpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int POOL_SIZE = 12;
  localparam int MAX_REPORTS = 10;

  // Predicts one result per transaction and checks results in order.
  class arp_scoreboard;
    logic [31:0]       own_ip;
    logic [47:0]       own_mac;
    bit                slot_valid [arpc_pkg::CACHE_ENTRIES];
    logic [31:0]       slot_ip [arpc_pkg::CACHE_ENTRIES];
    logic [47:0]       slot_mac [arpc_pkg::CACHE_ENTRIES];
    arpc_pkg::result_t expected_q [$];
    int unsigned       errors;

    function new();
      own_ip = '0;
      own_mac = '0;
      errors = 0;
      for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_ip[i] = '0;
        slot_mac[i] = '0;
      end
    endfunction

    function void write_reg(logic [arpc_pkg::CFG_IDX_W-1:0] idx,
                            logic [arpc_pkg::CFG_DATA_W-1:0] data);
      if (idx == arpc_pkg::CFG_OWN_IP) begin
        own_ip = data[31:0];
      end else if (idx == arpc_pkg::CFG_OWN_MAC) begin
        own_mac = data;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_item(arpc_pkg::item_t it);
      arpc_pkg::result_t r;
      int                match_idx;
      int                free_idx;
      int                slot;
      r = '0;
      match_idx = -1;
      free_idx = -1;
      if (it.req_type == arpc_pkg::REQ_LOOKUP) begin
        for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++) begin
          if (slot_valid[i] && slot_ip[i] == it.lookup_ip && match_idx < 0) match_idx = i;
        end
        if (match_idx >= 0) begin
          r.hit = 1'b1;
          r.found_mac = slot_mac[match_idx];
        end else begin
          r.send_kind = arpc_pkg::KIND_REQUEST;
          r.send_dst_mac = arpc_pkg::MAC_BCAST;
          r.send_target_ip = it.lookup_ip;
        end
      end else if (it.pkt_len < arpc_pkg::ARP_MIN_LEN) begin
        r.status = arpc_pkg::STATUS_SHORT;
      end else if (it.hw_type != arpc_pkg::HW_TYPE_ETH) begin
        r.status = arpc_pkg::STATUS_BAD_HW;
      end else if (it.hw_len != arpc_pkg::HW_LEN_ETH ||
                   it.paddr_len != arpc_pkg::PADDR_LEN_IP) begin
        r.status = arpc_pkg::STATUS_BAD_LEN;
      end else begin
        // learn sender: same IP wins, then lowest free slot, else evict oldest
        for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++) begin
          if (slot_valid[i] && slot_ip[i] == it.sender_ip && match_idx < 0) match_idx = i;
          if (!slot_valid[i] && free_idx < 0) free_idx = i;
        end
        if (match_idx >= 0) begin
          slot = match_idx;
        end else if (free_idx >= 0) begin
          slot = free_idx;
        end else begin
          for (int i = 1; i < arpc_pkg::CACHE_ENTRIES; i++) begin
            slot_valid[i-1] = slot_valid[i];
            slot_ip[i-1] = slot_ip[i];
            slot_mac[i-1] = slot_mac[i];
          end
          slot = arpc_pkg::CACHE_ENTRIES - 1;
        end
        slot_valid[slot] = 1'b1;
        slot_ip[slot] = it.sender_ip;
        slot_mac[slot] = it.sender_mac;
        if (it.opcode == arpc_pkg::OP_REQUEST && it.target_ip == own_ip) begin
          r.send_kind = arpc_pkg::KIND_REPLY;
          r.send_dst_mac = it.sender_mac;
          r.send_target_ip = it.sender_ip;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(arpc_pkg::result_t got);
      arpc_pkg::result_t exp_r;
      bit                bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result with no transaction pending: %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      bad = 1'b0;
      if (got.status !== exp_r.status) bad = 1'b1;
      if (got.hit !== exp_r.hit) bad = 1'b1;
      if (got.found_mac !== exp_r.found_mac) bad = 1'b1;
      if (got.send_kind !== exp_r.send_kind) bad = 1'b1;
      if (got.send_dst_mac !== exp_r.send_dst_mac) bad = 1'b1;
      if (got.send_target_ip !== exp_r.send_target_ip) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("ERROR at %0t: status %0d/%0d hit %0d/%0d mac %h/%h", $realtime,
                   exp_r.status, got.status, exp_r.hit, got.hit,
                   exp_r.found_mac, got.found_mac);
          $display("  kind %0d/%0d dst %h/%h tip %h/%h (expected/actual)",
                   exp_r.send_kind, got.send_kind, exp_r.send_dst_mac, got.send_dst_mac,
                   exp_r.send_target_ip, got.send_target_ip);
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  arpc_pkg::item_t                 in_item = '0;
  logic                            out_valid;
  arpc_pkg::result_t               out_result;
  logic                            cfg_we = 1'b0;
  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  arp_cache_and_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  arp_scoreboard book;
  logic [31:0]   ip_pool [POOL_SIZE];

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) book.check_result(out_result);
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 85) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arpc_pkg::item_t make_lookup(logic [31:0] ip);
    arpc_pkg::item_t it;
    it.req_type = arpc_pkg::REQ_LOOKUP;
    it.lookup_ip = ip;
    it.pkt_len = 16'($urandom);
    it.hw_type = 16'($urandom);
    it.hw_len = 8'($urandom);
    it.paddr_len = 8'($urandom);
    it.opcode = 16'($urandom);
    it.sender_ip = $urandom;
    it.sender_mac = rand48();
    it.target_ip = $urandom;
    return it;
  endfunction

  function automatic arpc_pkg::item_t make_pkt(logic [15:0] len, logic [15:0] hwt,
                                               logic [7:0] hwl, logic [7:0] prl,
                                               logic [15:0] op, logic [31:0] sip,
                                               logic [47:0] smac, logic [31:0] tip);
    arpc_pkg::item_t it;
    it.req_type = arpc_pkg::REQ_PACKET;
    it.lookup_ip = $urandom;
    it.pkt_len = len;
    it.hw_type = hwt;
    it.hw_len = hwl;
    it.paddr_len = prl;
    it.opcode = op;
    it.sender_ip = sip;
    it.sender_mac = smac;
    it.target_ip = tip;
    return it;
  endfunction

  // lookups and mostly well-formed packets on a small address pool so that hits,
  // overwrites and evictions are frequent; the other packets are malformed noise
  function automatic arpc_pkg::item_t rand_item();
    arpc_pkg::item_t it;
    int unsigned     roll;
    it = make_lookup($urandom);
    if ($urandom_range(0, 99) < 40) begin
      it.lookup_ip = pick_ip();
      return it;
    end
    it.req_type = arpc_pkg::REQ_PACKET;
    it.sender_ip = pick_ip();
    it.target_ip = $urandom_range(0, 1) ? book.own_ip : pick_ip();
    if ($urandom_range(0, 99) < 80) begin
      it.pkt_len = $urandom_range(0, 1) ? arpc_pkg::ARP_MIN_LEN :
                   16'($urandom_range(28, 65535));
      it.hw_type = arpc_pkg::HW_TYPE_ETH;
      it.hw_len = arpc_pkg::HW_LEN_ETH;
      it.paddr_len = arpc_pkg::PADDR_LEN_IP;
      roll = $urandom_range(0, 99);
      if (roll < 60) it.opcode = arpc_pkg::OP_REQUEST;
      else if (roll < 85) it.opcode = OP_REPLY;
    end else begin
      case ($urandom_range(0, 3))
        0: it.pkt_len = 16'($urandom_range(0, 27));
        1: begin
          it.pkt_len = 16'($urandom_range(28, 65535));
        end
        2: begin
          it.pkt_len = 16'($urandom_range(28, 65535));
          it.hw_type = arpc_pkg::HW_TYPE_ETH;
          if ($urandom_range(0, 1)) it.hw_len = arpc_pkg::HW_LEN_ETH;
          else it.paddr_len = arpc_pkg::PADDR_LEN_IP;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the transaction.
  task automatic drive_item(input arpc_pkg::item_t it, input int unsigned gap,
                            input bit drain);
    bit hold;
    hold = gap > 0 || (drain && book.pending() != 0);
    if (hold) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && book.pending() != 0) @(posedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    book.note_item(it);
  endtask

  task automatic cfg_write(input logic [arpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [arpc_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    book.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Registers change only with the block idle and nothing outstanding.
  task automatic set_regs(input logic [31:0] ip, input logic [47:0] mac);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_write(arpc_pkg::CFG_OWN_IP, {16'h0, ip});
    cfg_write(arpc_pkg::CFG_OWN_MAC, mac);
    cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, rand48());
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned idle_pct, input int unsigned count);
    int unsigned gap;
    for (int n = 0; n < count; n++) begin
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
      drive_item(rand_item(), gap, $urandom_range(0, 199) == 0);
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [31:0] me;
    book = new();
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cache, each drop reason, reply rules, overwrite, eviction
    me = 32'h0A00_00FE;
    set_regs(me, rand48());
    drive_item(make_lookup(32'h0), 0, 0);
    drive_item(make_lookup(32'hFFFF_FFFF), 0, 0);
    drive_item(make_pkt(16'd27, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, arpc_pkg::OP_REQUEST,
                        32'h0A00_0001, rand48(), me), 0, 0);
    drive_item(make_pkt(16'd0, 16'd0, 8'd0, 8'd0, arpc_pkg::OP_REQUEST, 32'h0A00_0001,
                        rand48(), me), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, 16'd0, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, arpc_pkg::OP_REQUEST,
                        32'h0A00_0001, rand48(), me), 0, 0);
    drive_item(make_pkt(16'hFFFF, 16'hFFFF, arpc_pkg::HW_LEN_ETH, arpc_pkg::PADDR_LEN_IP,
                        arpc_pkg::OP_REQUEST, 32'h0A00_0001, rand48(), me), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH, 8'd7,
                        arpc_pkg::PADDR_LEN_IP, arpc_pkg::OP_REQUEST,
                        32'h0A00_0001, rand48(), me), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        8'hFF, arpc_pkg::OP_REQUEST, 32'h0A00_0001, rand48(), me), 0, 0);
    drive_item(make_pkt(16'hFFFF, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, OP_REPLY, 32'h0, 48'h0, me), 0, 0);
    drive_item(make_lookup(32'h0), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, arpc_pkg::OP_REQUEST,
                        32'hFFFF_FFFF, arpc_pkg::MAC_BCAST, me), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, arpc_pkg::OP_REQUEST,
                        32'h1, rand48(), ~me), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, 16'hFFFF, 32'h2, rand48(), me), 0, 0);
    drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH, arpc_pkg::HW_LEN_ETH,
                        arpc_pkg::PADDR_LEN_IP, arpc_pkg::OP_REQUEST,
                        32'h0, rand48(), me), 0, 0);
    drive_item(make_lookup(32'h0), 0, 0);
    // cache holds four; seven more force three evictions
    for (int k = 0; k < 7; k++) begin
      drive_item(make_pkt(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_TYPE_ETH,
                          arpc_pkg::HW_LEN_ETH, arpc_pkg::PADDR_LEN_IP, OP_REPLY,
                          32'h0A00_0010 + k, rand48(), me), 0, 0);
    end
    drive_item(make_lookup(32'h0), 0, 0);
    drive_item(make_lookup(32'h0A00_0016), 0, 0);
    drive_item(make_lookup(32'h2), 0, 0);

    set_regs(32'h0, 48'h0);
    run_random(0, 390);
    set_regs(32'hFFFF_FFFF, arpc_pkg::MAC_BCAST);
    run_random(77, 390);
    set_regs($urandom, rand48());
    run_random(18, 390);
    set_regs(ip_pool[$urandom_range(2, POOL_SIZE - 1)], rand48());
    run_random(0, 390);

    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
